// ----- hdl/crr_pkg.sv -----
// shared types and constants of the composition rank and unrank unit
`default_nettype none

package crr_pkg;

  localparam int RANK_W     = 48;
  localparam int COUNT_W    = 6;
  localparam int WIDE_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int TOTAL_W    = 6;
  localparam int BINS_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ITEMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd1;

  localparam logic OP_RANK    = 1'b0;
  localparam logic OP_UNRANK  = 1'b1;
  localparam logic KIND_RANK  = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] bin_count_in;
    logic [RANK_W-1:0]  rank_index;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [RANK_W-1:0]  rank_value;
    logic [COUNT_W-1:0] bin_count_out;
    logic               last;
    logic               error;
  } out_t;

  typedef enum logic {
    ALU_ADD_SAT = 1'b0,
    ALU_SUB_CMP = 1'b1
  } alu_op_e;

endpackage

`default_nettype wire

// ----- hdl/crr_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module crr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 561
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/crr_alu.sv -----
// shared saturating adder and compare-subtract unit
`default_nettype none

module crr_alu #(
  parameter int INDEX_BITS = 48,
  parameter int VW         = 48
) (
  input  wire crr_pkg::alu_op_e op_i,
  input  wire logic [VW-1:0]    a_i,
  input  wire logic [VW-1:0]    b_i,
  output logic      [VW-1:0]    res_o,
  output logic                  lt_o
);

  import crr_pkg::*;

  logic [INDEX_BITS:0] sum;
  logic [VW:0]         diff;

  assign sum  = {1'b0, a_i[INDEX_BITS-1:0]} + {1'b0, b_i[INDEX_BITS-1:0]};
  assign diff = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    res_o = '0;
    lt_o  = 1'b0;
    case (op_i)
      ALU_ADD_SAT: begin
        // clamp to the all-ones index on carry out
        res_o = sum[INDEX_BITS] ? VW'({INDEX_BITS{1'b1}}) : VW'(sum[INDEX_BITS-1:0]);
      end
      ALU_SUB_CMP: begin
        res_o = diff[VW-1:0];
        lt_o  = diff[VW];
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/crr_ctrl.sv -----
// sequencer: table fill, rank accumulation and unrank table walk
`default_nettype none

module crr_ctrl #(
  parameter int MAX_ITEMS  = 32,
  parameter int MAX_BINS   = 16,
  parameter int INDEX_BITS = 48,
  parameter int IW         = $clog2(MAX_ITEMS + 1),
  parameter int BW         = $clog2(MAX_BINS + 1),
  parameter int AW         = $clog2((MAX_ITEMS + 1) * (MAX_BINS + 1)),
  parameter int VW         = (INDEX_BITS > 48) ? INDEX_BITS : 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [IW-1:0]         n_i,
  input  wire logic [BW-1:0]         w_i,
  input  wire logic                  run_clr_i,
  input  wire logic                  start_i,
  input  wire crr_pkg::in_t          cmd_i,
  output logic                       busy_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [INDEX_BITS-1:0]      ram_wdata_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  wire logic [INDEX_BITS-1:0] ram_rdata_i,
  output crr_pkg::alu_op_e           alu_op_o,
  output logic [VW-1:0]              alu_a_o,
  output logic [VW-1:0]              alu_b_o,
  input  wire logic [VW-1:0]         alu_res_i,
  input  wire logic                  alu_lt_i,
  output logic                       res_valid_o,
  output crr_pkg::out_t              res_o
);

  import crr_pkg::*;

  localparam int ROW = MAX_BINS + 1;

  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RSUM  = 6'b000100,
    S_UCHK  = 6'b001000,
    S_USTEP = 6'b010000,
    S_ULAST = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [IW-1:0]         fa_q, fa_d;
  logic [BW-1:0]         fb_q, fb_d;
  logic [INDEX_BITS-1:0] prev_q, prev_d;
  logic [INDEX_BITS-1:0] row_q [ROW];
  logic [INDEX_BITS-1:0] fill_cur;

  logic [INDEX_BITS-1:0] acc_q, acc_d;
  logic [IW-1:0]         left_q, left_d;
  logic [BW-1:0]         pos_q, pos_d;
  logic                  bad_q, bad_d;

  logic [BW-1:0]         ra_q, ra_d;
  logic [IW-1:0]         t_q, t_d;
  logic [IW-1:0]         r_q, r_d;
  logic [VW-1:0]         idx_q, idx_d;

  logic                  res_valid_q, res_valid_d;
  out_t                  res_q, res_d;

  logic [IW-1:0]         rd_a;
  logic [BW-1:0]         rd_b;

  // run state as seen by an arriving rank transfer
  logic                  restart;
  logic [BW-1:0]         pos_e, ra_e;
  logic [INDEX_BITS-1:0] acc_e;
  logic [IW-1:0]         left_e, left_new;
  logic                  bad_e, over, rank_err;
  logic [IW-1:0]         t_next;
  logic                  accept;
  logic [WIDE_W-1:0]     acc_wide;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);

  assign restart  = (pos_q == '0) || (pos_q >= w_i);
  assign pos_e    = restart ? '0 : pos_q;
  assign acc_e    = restart ? '0 : acc_q;
  assign left_e   = restart ? n_i : left_q;
  assign bad_e    = restart ? 1'b0 : bad_q;
  assign ra_e     = w_i - pos_e - BW'(1);
  assign over     = cmd_i.bin_count_in > COUNT_W'(left_e);
  assign left_new = left_e - IW'(cmd_i.bin_count_in);
  assign rank_err = bad_e || (cmd_i.bin_count_in != COUNT_W'(left_e));
  assign acc_wide = WIDE_W'(acc_e);
  assign t_next   = t_q + IW'(1);

  assign ram_waddr_o = AW'(int'(fa_q) * ROW + int'(fb_q));
  assign ram_raddr_o = AW'(int'(rd_a) * ROW + int'(rd_b));
  assign ram_wdata_o = fill_cur;

  always_comb begin
    state_d     = state_q;
    fa_d        = fa_q;
    fb_d        = fb_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    left_d      = left_q;
    pos_d       = pos_q;
    bad_d       = bad_q;
    ra_d        = ra_q;
    t_d         = t_q;
    r_d         = r_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    rd_a        = '0;
    rd_b        = '0;
    ram_we_o    = 1'b0;
    alu_op_o    = ALU_SUB_CMP;
    alu_a_o     = idx_q;
    alu_b_o     = VW'(ram_rdata_i);
    fill_cur    = '0;

    unique case (state_q)
      S_FILL: begin
        alu_op_o = ALU_ADD_SAT;
        alu_a_o  = VW'(prev_q);
        alu_b_o  = VW'(row_q[fb_q]);
        if (fa_q == '0) begin
          fill_cur = INDEX_BITS'(1);
        end else if (fb_q == '0) begin
          fill_cur = '0;
        end else begin
          fill_cur = alu_res_i[INDEX_BITS-1:0];
        end
        ram_we_o = 1'b1;
        prev_d   = fill_cur;
        if (fb_q == BW'(MAX_BINS)) begin
          fb_d = '0;
          if (fa_q == IW'(MAX_ITEMS)) begin
            state_d = S_IDLE;
          end else begin
            fa_d = fa_q + IW'(1);
          end
        end else begin
          fb_d = fb_q + BW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (cmd_i.op == OP_UNRANK) begin
            idx_d   = VW'(cmd_i.rank_index);
            rd_a    = n_i;
            rd_b    = w_i;
            state_d = S_UCHK;
          end else if (ra_e == '0) begin
            res_valid_d         = 1'b1;
            res_d.kind          = KIND_RANK;
            res_d.rank_value    = rank_err ? '0 : acc_wide[RANK_W-1:0];
            res_d.last          = 1'b1;
            res_d.error         = rank_err;
            pos_d               = '0;
            acc_d               = '0;
            left_d              = '0;
            bad_d               = 1'b0;
          end else if (over) begin
            bad_d  = 1'b1;
            left_d = '0;
            pos_d  = pos_e + BW'(1);
            acc_d  = acc_e;
          end else begin
            left_d = left_new;
            pos_d  = pos_e + BW'(1);
            acc_d  = acc_e;
            bad_d  = bad_e;
            if (left_new != '0) begin
              ra_d    = ra_e;
              t_d     = '0;
              rd_b    = ra_e;
              state_d = S_RSUM;
            end
          end
        end
      end

      S_RSUM: begin
        alu_op_o = ALU_ADD_SAT;
        alu_a_o  = VW'(acc_q);
        acc_d    = alu_res_i[INDEX_BITS-1:0];
        if (t_next != left_q) begin
          t_d  = t_next;
          rd_a = t_next;
          rd_b = ra_q;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_UCHK: begin
        res_d.kind = KIND_BIN;
        if (!alu_lt_i) begin
          // index not below the number of distributions
          res_valid_d = 1'b1;
          res_d.last  = 1'b1;
          res_d.error = 1'b1;
          state_d     = S_IDLE;
        end else if (w_i == BW'(1)) begin
          res_valid_d         = 1'b1;
          res_d.bin_count_out = COUNT_W'(n_i);
          res_d.last          = 1'b1;
          state_d             = S_IDLE;
        end else begin
          r_d     = n_i;
          t_d     = '0;
          ra_d    = w_i - BW'(1);
          rd_b    = w_i - BW'(1);
          state_d = S_USTEP;
        end
      end

      S_USTEP: begin
        res_d.kind = KIND_BIN;
        if (alu_lt_i || (t_q == r_q)) begin
          res_valid_d = 1'b1;
          if (alu_lt_i) begin
            res_d.bin_count_out = COUNT_W'(r_q - t_q);
            r_d                 = t_q;
          end else begin
            idx_d = alu_res_i;
          end
          if (ra_q == BW'(1)) begin
            state_d = S_ULAST;
          end else begin
            ra_d = ra_q - BW'(1);
            t_d  = '0;
            rd_b = ra_q - BW'(1);
          end
        end else begin
          idx_d = alu_res_i;
          t_d   = t_next;
          rd_a  = t_next;
          rd_b  = ra_q;
        end
      end

      S_ULAST: begin
        res_valid_d         = 1'b1;
        res_d.kind          = KIND_BIN;
        res_d.bin_count_out = COUNT_W'(r_q);
        res_d.last          = 1'b1;
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // writes to the item and bin registers drop a rank run in progress
    if (run_clr_i) begin
      pos_d  = '0;
      acc_d  = '0;
      left_d = '0;
      bad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      fa_q        <= '0;
      fb_q        <= '0;
      acc_q       <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      bad_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fa_q        <= fa_d;
      fb_q        <= fb_d;
      acc_q       <= acc_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      bad_q       <= bad_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    ra_q   <= ra_d;
    t_q    <= t_d;
    r_q    <= r_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    if (state_q == S_FILL) begin
      row_q[fb_q] <= fill_cur;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- hdl/composition_rank_unrank_unit.sv -----
// Ranks and unranks distributions of items over bins against a multichoose
// count table. After reset the table is filled one entry per cycle, all its
// (MAX_ITEMS+1)*(MAX_BINS+1) entries (561 at the defaults), with busy high;
// register writes are taken meanwhile. A rank transfer that leaves items for
// the bins after its own adds one table entry per item left, with busy high;
// the last bin of a run gives its answer the cycle after the transfer. An
// unrank transfer takes one table read for the range check, then one read per
// step of the table walk and a last state for the final bin, with one bin
// count appearing per step that closes a bin. The walk for a bin takes one
// step more than the items it leaves to the bins after it, so a whole walk is
// at most (MAX_BINS-1)*(MAX_ITEMS+1) steps (495 at the defaults). Every cycle
// is set by the single table read port feeding the one shared adder and
// subtracter. Results appear for one cycle under result_valid_o and cannot be
// held off.
`default_nettype none

module composition_rank_unrank_unit #(
  parameter int MAX_ITEMS  = 32,
  parameter int MAX_BINS   = 16,
  parameter int INDEX_BITS = 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire crr_pkg::in_t                   cmd_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [crr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [crr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                result_valid_o,
  output crr_pkg::out_t                       result_o
);

  import crr_pkg::*;

  localparam int ROW   = MAX_BINS + 1;
  localparam int DEPTH = (MAX_ITEMS + 1) * ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_ITEMS + 1);
  localparam int BW    = $clog2(MAX_BINS + 1);
  localparam int VW    = (INDEX_BITS > RANK_W) ? INDEX_BITS : RANK_W;

  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [BINS_W-1:0]     bins_q, bins_d;
  logic                  cfg_wr, run_clr;
  logic [IW-1:0]         n_eff;
  logic [BW-1:0]         w_eff;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [INDEX_BITS-1:0] ram_wdata, ram_rdata;
  alu_op_e               alu_op;
  logic [VW-1:0]         alu_a, alu_b, alu_res;
  logic                  alu_lt;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    total_d = total_q;
    bins_d  = bins_q;
    run_clr = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_TOTAL_ITEMS: begin
          total_d = cfg_data_i[TOTAL_W-1:0];
          run_clr = 1'b1;
        end
        CFG_BINS_IN_USE: begin
          bins_d  = cfg_data_i[BINS_W-1:0];
          run_clr = 1'b1;
        end
        default: begin
          run_clr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      bins_q  <= BINS_W'(1);
    end else begin
      total_q <= total_d;
      bins_q  <= bins_d;
    end
  end

  // clamp register values to the sizes the table covers
  assign n_eff = (int'(total_q) > MAX_ITEMS) ? IW'(MAX_ITEMS) : IW'(total_q);
  assign w_eff = (bins_q == '0) ? BW'(1) :
                 (int'(bins_q) > MAX_BINS) ? BW'(MAX_BINS) : BW'(bins_q);

  crr_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  crr_alu #(
    .INDEX_BITS (INDEX_BITS),
    .VW         (VW)
  ) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  crr_ctrl #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_BINS   (MAX_BINS),
    .INDEX_BITS (INDEX_BITS),
    .IW         (IW),
    .BW         (BW),
    .AW         (AW),
    .VW         (VW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .w_i         (w_eff),
    .run_clr_i   (run_clr),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .busy_o      (busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .alu_op_o    (alu_op),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_res_i   (alu_res),
    .alu_lt_i    (alu_lt),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

`ifndef NO_ASSERTIONS
  // an error result is always the only and final one of its run
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.error |->
      result_o.last && (result_o.rank_value == '0) && (result_o.bin_count_out == '0))
    else $error("error result not clean");

  // rank answers only ever close a run
  a_rank_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.kind == KIND_RANK) |-> result_o.last)
    else $error("rank answer without last");

  // an unrank transfer always needs the table, so the unit goes busy
  a_unrank_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.op == OP_UNRANK) |=> busy)
    else $error("unrank transfer did not start the walk");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_composition_rank_unrank_unit.sv -----
// self-checking testbench for the composition rank and unrank unit
`timescale 1ns / 1ps

module tb_composition_rank_unrank_unit;
  import crr_pkg::*;

  localparam int MAX_ITEMS     = 32;
  localparam int MAX_BINS      = 16;
  localparam int SETTLE_CYCLES = MAX_ITEMS + 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int LIMIT_CYCLES  = 2000000;

  // register indexes the unit does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  cmd_start = 1'b0;
  logic                  cmd_busy;
  in_t                   cmd_bus   = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  res_valid;
  out_t                  res_bus;

  composition_rank_unrank_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (cmd_start),
    .busy           (cmd_busy),
    .cmd_i          (cmd_bus),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .result_valid_o (res_valid),
    .result_o       (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // multichoose counts: ways to put a items into b bins, saturating
  logic [RANK_W-1:0] multichoose [0:MAX_ITEMS][0:MAX_BINS];

  // predictor copy of the registers and of the rank run in progress
  logic [TOTAL_W-1:0] reg_total;
  logic [BINS_W-1:0]  reg_bins;
  logic [RANK_W-1:0]  run_acc;
  int                 run_left;
  int                 run_pos;
  logic               run_bad;

  out_t pending_results [$];

  int idle_pct      = 0;
  int rank_sent     = 0;
  int unrank_sent   = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  function automatic logic [RANK_W-1:0] sat48(input logic [RANK_W-1:0] a,
                                               input logic [RANK_W-1:0] b);
    logic [RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RANK_W] ? '1 : s[RANK_W-1:0];
  endfunction

  function automatic int used_items();
    return (reg_total > MAX_ITEMS) ? MAX_ITEMS : int'(reg_total);
  endfunction

  function automatic int used_bins();
    if (reg_bins == 0) return 1;
    return (reg_bins > MAX_BINS) ? MAX_BINS : int'(reg_bins);
  endfunction

  function automatic logic [RANK_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[RANK_W-1:0];
  endfunction

  function automatic void queue_answer(input logic kind, input logic [RANK_W-1:0] value,
                                       input logic [COUNT_W-1:0] count, input logic last,
                                       input logic err);
    out_t r;
    r.kind          = kind;
    r.rank_value    = value;
    r.bin_count_out = count;
    r.last          = last;
    r.error         = err;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_rank(input logic [COUNT_W-1:0] v);
    int   w;
    int   ra;
    logic err;
    w = used_bins();
    if (run_pos == 0 || run_pos >= w) begin
      run_pos  = 0;
      run_acc  = '0;
      run_left = used_items();
      run_bad  = 1'b0;
    end
    ra = w - run_pos - 1;
    if (ra == 0) begin
      err = run_bad || (int'(v) != run_left);
      queue_answer(KIND_RANK, err ? '0 : run_acc, '0, 1'b1, err);
      run_pos  = 0;
      run_acc  = '0;
      run_left = 0;
      run_bad  = 1'b0;
    end else begin
      // a count above what is left poisons the run until its last bin
      if (int'(v) > run_left) begin
        run_bad  = 1'b1;
        run_left = 0;
      end else begin
        run_left -= int'(v);
        for (int s = 0; s < run_left; s++) run_acc = sat48(run_acc, multichoose[s][ra]);
      end
      run_pos++;
    end
  endfunction

  function automatic void predict_unrank(input logic [RANK_W-1:0] index);
    int                n;
    int                w;
    int                rest;
    int                h;
    int                ra;
    logic              found;
    logic [RANK_W-1:0] idx;
    logic [RANK_W-1:0] span;
    n   = used_items();
    w   = used_bins();
    idx = index;
    if (idx >= multichoose[n][w]) begin
      queue_answer(KIND_BIN, '0, '0, 1'b1, 1'b1);
      return;
    end
    rest = n;
    for (int l = 0; l + 1 < w; l++) begin
      ra    = w - l - 1;
      h     = rest;
      found = 1'b0;
      // walk down from the fullest bin until the index falls inside a block
      while (!found) begin
        span = multichoose[rest - h][ra];
        if (idx < span) begin
          found = 1'b1;
        end else begin
          idx -= span;
          if (h == 0) found = 1'b1;
          else h--;
        end
      end
      queue_answer(KIND_BIN, '0, COUNT_W'(h), 1'b0, 1'b0);
      rest -= h;
    end
    queue_answer(KIND_BIN, '0, COUNT_W'(rest), 1'b1, 1'b0);
  endfunction

  // one command transfer; start stays high afterwards for a following command
  task automatic issue_cmd(input in_t c);
    if ($urandom_range(99) < idle_pct) begin
      cmd_start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    cmd_start <= 1'b1;
    cmd_bus   <= c;
    do @(posedge clk_i); while (cmd_busy);
    if (c.op == OP_UNRANK) begin
      predict_unrank(c.rank_index);
      unrank_sent++;
    end else begin
      predict_rank(c.bin_count_in);
      rank_sent++;
    end
  endtask

  task automatic send_rank(input logic [COUNT_W-1:0] v);
    in_t c;
    c.op           = OP_RANK;
    c.bin_count_in = v;
    c.rank_index   = rand48();
    issue_cmd(c);
  endtask

  task automatic send_unrank(input logic [RANK_W-1:0] index);
    in_t c;
    c.op           = OP_UNRANK;
    c.bin_count_in = COUNT_W'($urandom_range(MAX_ITEMS));
    c.rank_index   = index;
    issue_cmd(c);
  endtask

  // register writes only once the unit has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cmd_start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (cmd_busy) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == CFG_TOTAL_ITEMS || idx == CFG_BINS_IN_USE) begin
      if (idx == CFG_TOTAL_ITEMS) reg_total = data[TOTAL_W-1:0];
      else reg_bins = data[BINS_W-1:0];
      run_pos  = 0;
      run_acc  = '0;
      run_left = 0;
      run_bad  = 1'b0;
    end
  endtask

  task automatic test_reset_state();
    send_unrank('0);
    send_unrank(48'd1);
    send_rank(6'd0);
    send_rank(6'd5);
  endtask

  task automatic test_wide_space();
    write_reg(CFG_TOTAL_ITEMS, 6'd32);
    write_reg(CFG_BINS_IN_USE, 6'd16);
    send_unrank('0);
    send_unrank(multichoose[MAX_ITEMS][MAX_BINS] - 1'b1);
    send_unrank(multichoose[MAX_ITEMS][MAX_BINS]);
    send_unrank('1);
  endtask

  task automatic test_rank_extremes();
    write_reg(CFG_BINS_IN_USE, 6'd2);
    send_rank(6'd32);
    send_rank(6'd0);
    send_rank(6'd0);
    send_rank(6'd32);
  endtask

  task automatic test_sum_mismatch();
    write_reg(CFG_TOTAL_ITEMS, 6'd10);
    send_rank(6'd20);
    send_rank(6'd5);
    send_rank(6'd3);
    send_rank(6'd4);
  endtask

  task automatic test_interleave();
    send_rank(6'd3);
    send_unrank(48'd4);
    send_rank(6'd7);
  endtask

  task automatic test_abandon();
    send_rank(6'd6);
    write_reg(CFG_TOTAL_ITEMS, 6'd10);
    send_rank(6'd2);
    send_rank(6'd8);
    // writes to undecoded indexes leave the run alone
    send_rank(6'd2);
    write_reg(CFG_SPARE_A, 6'h2a);
    write_reg(CFG_SPARE_B, 6'h15);
    send_rank(6'd8);
  endtask

  task automatic test_register_clamp();
    write_reg(CFG_TOTAL_ITEMS, 6'h3f);
    write_reg(CFG_BINS_IN_USE, 6'h3f);
    send_unrank(multichoose[MAX_ITEMS][MAX_BINS] - 1'b1);
    write_reg(CFG_BINS_IN_USE, 6'd0);
    send_unrank('0);
  endtask

  task automatic test_random_traffic(input int pct, input int quota);
    int                 base;
    int                 roll;
    int                 n;
    int                 w;
    int                 len;
    int                 counts [MAX_BINS];
    logic [RANK_W-1:0]  cnt;
    logic [63:0]        r;
    logic [CFG_DATA_W-1:0] data;
    idle_pct = pct;
    for (int half = 0; half < 2; half++) begin
      roll = $urandom_range(99);
      if (roll < 15) data = ($urandom_range(1) != 0) ? 6'd32 : 6'd0;
      else if (roll < 25) data = CFG_DATA_W'($urandom_range(63, 33));
      else data = CFG_DATA_W'($urandom_range(MAX_ITEMS, 1));
      write_reg(CFG_TOTAL_ITEMS, data);
      roll = $urandom_range(99);
      if (roll < 15) data = ($urandom_range(1) != 0) ? 6'd16 : 6'd1;
      else if (roll < 25) data = {1'($urandom_range(1)), 5'($urandom_range(1) != 0 ?
                                  $urandom_range(31, 17) : 0)};
      else data = CFG_DATA_W'($urandom_range(MAX_BINS, 2));
      write_reg(CFG_BINS_IN_USE, data);
      base = rank_sent + unrank_sent;
      while (rank_sent + unrank_sent - base < quota / 2) begin
        n    = used_items();
        w    = used_bins();
        roll = $urandom_range(99);
        if (roll < 65) begin
          foreach (counts[i]) counts[i] = 0;
          repeat (n) counts[$urandom_range(w - 1)]++;
          len  = w;
          roll = $urandom_range(99);
          // mostly well-formed runs, some with a bad count or cut short
          if (roll < 12) counts[$urandom_range(w - 1)] = $urandom_range(MAX_ITEMS);
          else if (roll < 18) len = $urandom_range(w - 1);
          for (int i = 0; i < len; i++) send_rank(COUNT_W'(counts[i]));
        end else begin
          cnt  = multichoose[n][w];
          r    = {$urandom, $urandom};
          roll = $urandom_range(99);
          if (roll < 80) send_unrank(RANK_W'(r % {16'd0, cnt}));
          else if (roll < 94) send_unrank(cnt + RANK_W'($urandom_range(2)));
          else send_unrank(r[RANK_W-1:0]);
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", res_bus);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, res_bus.kind);
        check_field("rank_value", want.rank_value, res_bus.rank_value);
        check_field("bin_count_out", want.bin_count_out, res_bus.bin_count_out);
        check_field("last", want.last, res_bus.last);
        check_field("error", want.error, res_bus.error);
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL composition_rank_unrank_unit");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a <= MAX_ITEMS; a++) begin
      for (int b = 0; b <= MAX_BINS; b++) begin
        if (b == 0) multichoose[a][b] = (a == 0) ? 48'd1 : 48'd0;
        else if (a == 0) multichoose[a][b] = 48'd1;
        else multichoose[a][b] = sat48(multichoose[a][b-1], multichoose[a-1][b]);
      end
    end
    reg_total = '0;
    reg_bins  = BINS_W'(1);
    run_acc   = '0;
    run_left  = 0;
    run_pos   = 0;
    run_bad   = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_wide_space();
    test_rank_extremes();
    test_sum_mismatch();
    test_interleave();
    test_abandon();
    test_register_clamp();
    test_random_traffic(0, 112);
    test_random_traffic(48, 112);
    test_random_traffic(0, 112);
    test_random_traffic(12, 112);

    cmd_start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d rank and %0d unrank commands, %0d results checked,",
             rank_sent, unrank_sent, results_seen);
    $display("%0d register writes across several settings, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS composition_rank_unrank_unit");
    end else begin
      $display("FAIL composition_rank_unrank_unit");
    end
    $finish;
  end

endmodule
